@@ rtl/core/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, field widths and codes for the three-stack shared pool.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int VALUE_W = 32;
   localparam int SID_W   = 2;
   localparam int STATUS_W = 2;

   localparam int DEF_POOL_DEPTH = 16;
   localparam int DEF_NUM_STACKS = 3;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POOL_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STACK_EMPTY = 2'd2;

   // requests from the control path to the free list
   typedef struct packed {
      logic fetch;   // read the top free slot
      logic take;    // commit a push: one slot leaves the free list
      logic give;    // commit a pop: a slot returns to the free list
   } fl_ctrl_type;

endpackage

@@ rtl/core/tsp_if.sv @@
// ----------------------------------------------------------------------------
// tsp_if
// Request and response channels of the three-stack shared pool.
// ----------------------------------------------------------------------------
interface tsp_req_if;
   import tsp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [SID_W-1:0]          stack_id;
   logic signed [VALUE_W-1:0] push_value;

   modport source (output valid, output action, output stack_id, output push_value,
                   input ready);
   modport sink   (input valid, input action, input stack_id, input push_value,
                   output ready);
endinterface

interface tsp_rsp_if;
   import tsp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] pop_value;
   logic [STATUS_W-1:0]       status;
   logic                      stack_empty;
   logic                      pool_full;

   modport source (output valid, output pop_value, output status, output stack_empty,
                   output pool_full, input ready);
   modport sink   (input valid, input pop_value, input status, input stack_empty,
                   input pool_full, output ready);
endinterface

@@ rtl/core/tsp_node_mem.sv @@
// ----------------------------------------------------------------------------
// tsp_node_mem
// Node storage: value and link to the node below, one read and one write port.
// ----------------------------------------------------------------------------
module tsp_node_mem #(
   parameter int POOL_DEPTH = tsp_pkg::DEF_POOL_DEPTH,
   parameter int IW         = 4,
   parameter int LW         = 5
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [IW-1:0]                      wr_addr,
   input  logic [tsp_pkg::VALUE_W-1:0]        wr_value,
   input  logic [LW-1:0]                      wr_link,
   input  logic                               rd_en,
   input  logic [IW-1:0]                      rd_addr,
   output logic [tsp_pkg::VALUE_W-1:0]        rd_value,
   output logic [LW-1:0]                      rd_link
);
   import tsp_pkg::*;

   localparam int NW = VALUE_W + LW;

   logic [NW-1:0] mem [POOL_DEPTH];
   logic [NW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_value, wr_link};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_value = rd_data_ff[NW-1:LW];
   assign rd_link  = rd_data_ff[LW-1:0];

endmodule

@@ rtl/core/tsp_free_list.sv @@
// ----------------------------------------------------------------------------
// tsp_free_list
// Free-slot stack in memory with its fill count. Entries below the low-water
// mark were never written and read back as their reset value.
// ----------------------------------------------------------------------------
module tsp_free_list #(
   parameter int POOL_DEPTH = tsp_pkg::DEF_POOL_DEPTH,
   parameter int IW         = 4,
   parameter int CW         = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsp_pkg::fl_ctrl_type ctrl,
   input  logic [IW-1:0]        give_slot,
   output logic [CW-1:0]        count,
   output logic [IW-1:0]        top_slot
);
   import tsp_pkg::*;

   logic [IW-1:0] mem [POOL_DEPTH];
   logic [IW-1:0] rd_data_ff;
   logic [IW-1:0] reset_slot_ff;
   logic [IW-1:0] reset_slot_in;
   logic          use_reset_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] low_ff;
   logic [CW-1:0] low_in;
   logic [CW-1:0] rd_ptr;

   always_comb begin
      rd_ptr = count_ff - CW'(1);
      // reset image of entry i is depth-1-i, so at count-1 it is depth-count
      reset_slot_in = IW'(CW'(POOL_DEPTH) - count_ff);
      count_in = count_ff;
      if (ctrl.take) begin
         count_in = count_ff - CW'(1);
      end else if (ctrl.give) begin
         count_in = count_ff + CW'(1);
      end
      low_in = low_ff;
      if (ctrl.give && (count_ff < low_ff)) begin
         low_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(POOL_DEPTH);
         low_ff   <= CW'(POOL_DEPTH);
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
      end
      if (ctrl.give) begin
         mem[count_ff[IW-1:0]] <= give_slot;
      end
      if (ctrl.fetch) begin
         rd_data_ff    <= mem[rd_ptr[IW-1:0]];
         use_reset_ff  <= rd_ptr < low_ff;
         reset_slot_ff <= reset_slot_in;
      end
   end

   assign count    = count_ff;
   assign top_slot = use_reset_ff ? reset_slot_ff : rd_data_ff;

endmodule

@@ rtl/core/three_stacks_shared_pool.sv @@
// ----------------------------------------------------------------------------
// three_stacks_shared_pool
// LIFO stacks sharing one node pool, with a free-slot stack handing out nodes.
//
//   channel   dir   word
//   req_bus   in    action, stack_id, push_value
//   rsp_bus   out   pop_value, status, stack_empty, pool_full
//
// On accept a word issues the node or free-slot memory read; in the EXEC
// state it writes back and loads the response register.
// A new word is accepted once the previous one has been written back.
// A stalled response holds the EXEC state; no new word enters meanwhile.
// Reset is synchronous and needs no clearing pass: unwritten free-list entries
// are served from their reset image via a low-water mark.
// ----------------------------------------------------------------------------
module three_stacks_shared_pool #(
   parameter int POOL_DEPTH = tsp_pkg::DEF_POOL_DEPTH,
   parameter int NUM_STACKS = tsp_pkg::DEF_NUM_STACKS
) (
   input logic     clock,
   input logic     reset,
   tsp_req_if.sink   req_bus,
   tsp_rsp_if.source rsp_bus
);
   import tsp_pkg::*;

   localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int LW = $clog2(POOL_DEPTH + 1);
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam int SW = $clog2(NUM_STACKS);
   localparam logic [LW-1:0] LINK_NULL = LW'(POOL_DEPTH);

   typedef enum logic {IDLE, EXEC} state_type;

   state_type                 state_ff;
   logic                      act_ff;
   logic [SW-1:0]             sidx_ff;
   logic                      mapped_ff;
   logic [VALUE_W-1:0]        val_ff;
   logic [STATUS_W-1:0]       status_ff;
   logic [LW-1:0]             head_ff;
   logic [LW-1:0]             heads_ff [NUM_STACKS];

   logic                      rsp_valid_ff;
   logic [VALUE_W-1:0]        rsp_pop_value_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic                      rsp_empty_ff;
   logic                      rsp_full_ff;

   logic [SID_W:0]            sid_ext;
   logic [SW-1:0]             acc_sidx;
   logic                      acc_mapped;
   logic [LW-1:0]             acc_head;
   logic [STATUS_W-1:0]       acc_status;
   logic                      accept;
   logic                      exec_fire;
   logic                      commit;

   fl_ctrl_type               fl_ctrl;
   logic [CW-1:0]             fl_count;
   logic [IW-1:0]             fl_slot;
   logic [VALUE_W-1:0]        nd_value;
   logic [LW-1:0]             nd_link;

   assign req_bus.ready = (state_ff == IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign exec_fire     = (state_ff == EXEC) && (!rsp_valid_ff || rsp_bus.ready);
   assign commit        = exec_fire && (status_ff == STATUS_OK);

   always_comb begin
      sid_ext    = {1'b0, req_bus.stack_id};
      acc_sidx   = sid_ext[SW-1:0];
      acc_mapped = int'(req_bus.stack_id) < NUM_STACKS;
      acc_head   = acc_mapped ? heads_ff[acc_sidx] : LINK_NULL;
      acc_status = STATUS_OK;
      if (req_bus.action == ACTION_PUSH) begin
         if (!acc_mapped || (fl_count == CW'(0))) begin
            acc_status = STATUS_POOL_FULL;
         end
      end else if (acc_head == LINK_NULL) begin
         acc_status = STATUS_STACK_EMPTY;
      end
      fl_ctrl.fetch = accept && (req_bus.action == ACTION_PUSH) && (acc_status == STATUS_OK);
      fl_ctrl.take  = commit && (act_ff == ACTION_PUSH);
      fl_ctrl.give  = commit && (act_ff == ACTION_POP);
   end

   tsp_free_list #(
      .POOL_DEPTH (POOL_DEPTH),
      .IW         (IW),
      .CW         (CW)
   ) u_free_list (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (fl_ctrl),
      .give_slot (head_ff[IW-1:0]),
      .count     (fl_count),
      .top_slot  (fl_slot)
   );

   tsp_node_mem #(
      .POOL_DEPTH (POOL_DEPTH),
      .IW         (IW),
      .LW         (LW)
   ) u_node_mem (
      .clock    (clock),
      .wr_en    (fl_ctrl.take),
      .wr_addr  (fl_slot),
      .wr_value (val_ff),
      .wr_link  (head_ff),
      .rd_en    (accept && (req_bus.action == ACTION_POP) && (acc_status == STATUS_OK)),
      .rd_addr  (acc_head[IW-1:0]),
      .rd_value (nd_value),
      .rd_link  (nd_link)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            heads_ff[i] <= LINK_NULL;
         end
      end else begin
         // a new word may refill the response register as the old one leaves
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= EXEC;
               end
            end
            EXEC: begin
               if (exec_fire) begin
                  state_ff <= IDLE;
               end
               if (commit) begin
                  heads_ff[sidx_ff] <= (act_ff == ACTION_PUSH) ? LW'(fl_slot) : nd_link;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end

      if (accept) begin
         act_ff    <= req_bus.action;
         sidx_ff   <= acc_sidx;
         mapped_ff <= acc_mapped;
         val_ff    <= req_bus.push_value;
         status_ff <= acc_status;
         head_ff   <= acc_head;
      end

      if (exec_fire) begin
         rsp_status_ff <= status_ff;
         if (status_ff != STATUS_OK) begin
            rsp_pop_value_ff <= '0;
            rsp_empty_ff     <= !mapped_ff || (head_ff == LINK_NULL);
            rsp_full_ff      <= (fl_count == CW'(0));
         end else if (act_ff == ACTION_PUSH) begin
            rsp_pop_value_ff <= '0;
            rsp_empty_ff     <= 1'b0;
            rsp_full_ff      <= (fl_count == CW'(1));
         end else begin
            rsp_pop_value_ff <= nd_value;
            rsp_empty_ff     <= (nd_link == LINK_NULL);
            rsp_full_ff      <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pop_value   = rsp_pop_value_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.stack_empty = rsp_empty_ff;
   assign rsp_bus.pool_full   = rsp_full_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      fl_count <= CW'(POOL_DEPTH))
      else $error("free count above pool depth");

   a_push_takes: assert property (@(posedge clock) disable iff (reset)
      commit && (act_ff == ACTION_PUSH) |=> fl_count == $past(fl_count) - CW'(1))
      else $error("push did not take a free slot");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      exec_fire && (status_ff != STATUS_OK) |=> $stable(fl_count))
      else $error("rejected word changed the free count");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_full_ff == (fl_count == CW'(0)))
      else $error("pool_full disagrees with free count");
`endif

endmodule
